// ===== src/urd_pkg.sv =====
// ----------------------------------------------------------------------------
// urd_pkg : shared definitions for the radix digit converter
// Constants and the status type passed from the divider to the sequencer.
// ----------------------------------------------------------------------------
package urd_pkg;

    // Width of the value field on the input request
    localparam int VALUE_FIELD_W  = 32;
    // Width of the base field on the input request
    localparam int BASE_W         = 5;
    // Default operand width
    localparam int VALUE_BITS_DEF = 32;
    // Dividend bits retired by the divider per cycle
    localparam int DIV_STEP       = 8;
    // Remainder width; the base never exceeds sixteen
    localparam int DIGIT_W        = 4;
    // Character width on the output
    localparam int CHAR_W         = 6;

    localparam logic [BASE_W-1:0] RADIX_MIN  = 5'd2;
    localparam logic [BASE_W-1:0] RADIX_MAX  = 5'd16;
    localparam logic [CHAR_W-1:0] DIGIT_ZERO = 6'd48;

    typedef struct packed {
        logic               done;
        logic [DIGIT_W-1:0] remainder;
    } div_stat_t;

endpackage

// ===== src/urd_div.sv =====
// ----------------------------------------------------------------------------
// urd_div : shared iterative divider
// Restoring division of a wide dividend by a small radix, several bits a cycle.
// ----------------------------------------------------------------------------
module urd_div #(
    parameter int QW = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [QW-1:0]             dividend,
    input  logic [urd_pkg::BASE_W-1:0] divisor,
    output logic [QW-1:0]             quotient,
    output urd_pkg::div_stat_t        stat
);
    import urd_pkg::*;

    localparam int CHUNKS = QW / DIV_STEP;
    localparam int CNT_W  = $clog2(CHUNKS + 1);

    logic [QW-1:0]      work_reg, work_next;
    logic [DIGIT_W-1:0] rem_reg, rem_next;
    logic [BASE_W-1:0]  div_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic               busy_reg;
    logic               done_reg;

    // eight restoring steps on the top bits of the work register
    always_comb begin
        logic [QW-1:0]      w;
        logic [DIGIT_W-1:0] r;
        logic [BASE_W-1:0]  t;
        logic               q;
        w = work_reg;
        r = rem_reg;
        for (int i = 0; i < DIV_STEP; i++) begin
            t = {r, w[QW-1]};
            q = (t >= div_reg);
            if (q) begin
                t = t - div_reg;
            end
            r = t[DIGIT_W-1:0];
            w = {w[QW-2:0], q};
        end
        work_next = w;
        rem_next  = r;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(CHUNKS);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            work_reg <= dividend;
            rem_reg  <= '0;
            div_reg  <= divisor;
        end else if (busy_reg) begin
            work_reg <= work_next;
            rem_reg  <= rem_next;
        end
    end

    assign quotient       = work_reg;
    assign stat.done      = done_reg;
    assign stat.remainder = rem_reg;

endmodule

// ===== src/unsigned_to_radix_digits_unit.sv =====
// ----------------------------------------------------------------------------
// unsigned_to_radix_digits_unit : unsigned value to ASCII digit string
// Divides the value by the base repeatedly, keeps the remainders and sends
// them back most significant first as characters '0' + digit.
// ----------------------------------------------------------------------------
//
//  channel  | dir | payload                                 | framing
//  ---------+-----+-----------------------------------------+------------------
//  s_       | in  | tdata[31:0] value, tdata[36:32] base    | one request/number
//  m_       | out | tdata[5:0] digit_char                   | tlast on last char
//
//  Each digit is one pass through the shared divider. All digits of a number
//  are divided before any of them is sent; base two gives the most digits.
//  s_tready is high only while the sequencer is idle; the final character may
//  still wait in the output register while the next request is taken.
//  A stalled m_ side holds the drain; nothing is lost or repeated.
//  Reset (aresetn low, synchronous) clears the sequencer and output valid; the
//  digit store is not cleared, as every entry is written before it is read.
//  Base fields below two act as two, above sixteen as sixteen.
// ----------------------------------------------------------------------------
module unsigned_to_radix_digits_unit #(
    parameter int VALUE_BITS = urd_pkg::VALUE_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] value, [36:32] base, [39:37] zero
    // result characters
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic        m_tlast
);
    import urd_pkg::*;

    // divider operand padded to whole steps
    localparam int QW = ((VALUE_BITS + DIV_STEP - 1) / DIV_STEP) * DIV_STEP;
    localparam int AW = $clog2(VALUE_BITS);
    localparam int CW = $clog2(VALUE_BITS + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [AW-1:0]       rd_idx_reg, rd_idx_next;
    logic                drain_left_reg, drain_left_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [BASE_W-1:0]   radix_reg;
    logic [DIGIT_W-1:0]  rd_data_reg;
    logic                rd_last_reg;
    logic                m_valid_reg, m_valid_next;
    logic [CHAR_W-1:0]   m_char_reg;
    logic                m_last_reg;

    // digit store, least significant digit at entry zero
    logic [DIGIT_W-1:0]  store_mem [VALUE_BITS];

    logic                accept;
    logic [BASE_W-1:0]   base_in, radix_in;
    logic [63:0]         value_wide;
    logic [QW-1:0]       operand;
    logic                div_start;
    logic [QW-1:0]       div_dividend;
    logic [QW-1:0]       div_quot;
    div_stat_t           div_stat;
    logic                last_digit;
    logic                store_wr;
    logic                out_free;
    logic                load;
    logic                issue;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // drop value bits above VALUE_BITS, saturate the base into 2..16
    assign value_wide = {32'd0, s_tdata[VALUE_FIELD_W-1:0]};
    assign operand    = QW'(value_wide[VALUE_BITS-1:0]);
    assign base_in    = s_tdata[VALUE_FIELD_W +: BASE_W];
    assign radix_in   = (base_in < RADIX_MIN) ? RADIX_MIN :
                        (base_in > RADIX_MAX) ? RADIX_MAX : base_in;

    assign last_digit = (div_quot == '0) || (count_reg == CW'(VALUE_BITS - 1));
    assign store_wr   = (state_reg == ST_DIV) && div_stat.done;

    // restart the divider on the running quotient after each digit but the last
    assign div_start    = accept || (store_wr && !last_digit);
    assign div_dividend = (state_reg == ST_IDLE) ? operand : div_quot;

    urd_div #(
        .QW (QW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  ((state_reg == ST_IDLE) ? radix_in : radix_reg),
        .quotient (div_quot),
        .stat     (div_stat)
    );

    // drain pipeline: read the store, then load the output register
    assign out_free = !m_valid_reg || m_tready;
    assign load     = rd_pend_reg && out_free;
    assign issue    = (state_reg == ST_DRAIN) && drain_left_reg && (!rd_pend_reg || load);

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        drain_left_next = drain_left_reg;
        rd_pend_next    = rd_pend_reg;
        m_valid_next    = m_valid_reg;

        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end

        if (issue) begin
            rd_pend_next = 1'b1;
            rd_idx_next  = rd_idx_reg - 1'b1;
            if (rd_idx_reg == '0) begin
                drain_left_next = 1'b0;
            end
        end else if (load) begin
            rd_pend_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_DIV;
                    count_next = '0;
                end
            end
            ST_DIV: begin
                if (div_stat.done) begin
                    if (last_digit) begin
                        state_next      = ST_DRAIN;
                        rd_idx_next     = count_reg[AW-1:0];
                        drain_left_next = 1'b1;
                    end else begin
                        count_next = count_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN: begin
                if (!drain_left_reg && !rd_pend_reg) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            rd_idx_reg     <= '0;
            drain_left_reg <= 1'b0;
            rd_pend_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            rd_idx_reg     <= rd_idx_next;
            drain_left_reg <= drain_left_next;
            rd_pend_reg    <= rd_pend_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            radix_reg <= radix_in;
        end
        if (load) begin
            m_char_reg <= DIGIT_ZERO + CHAR_W'(rd_data_reg);
            m_last_reg <= rd_last_reg;
        end
    end

    // digit store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (store_wr) begin
            store_mem[count_reg[AW-1:0]] <= div_stat.remainder;
        end
        if (issue) begin
            rd_data_reg <= store_mem[rd_idx_reg];
            rd_last_reg <= (rd_idx_reg == '0);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_char_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== src/urd_checker.sv =====
// ----------------------------------------------------------------------------
// urd_checker : port-level checks for the radix digit converter
// Watches the handshakes and the character range on the top-level ports.
// ----------------------------------------------------------------------------
module urd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // a request starts a conversion, so the unit is busy on the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("unit still ready after taking a request");

    // a stalled character holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled character changed");

    // characters lie in '0' .. '?'
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7:4] == 4'b0011))
        else $error("character out of range");

    // only the final character of a number may wait while the unit is idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && m_tvalid |-> m_tlast)
        else $error("unit idle with characters still to send");

endmodule

bind unsigned_to_radix_digits_unit urd_checker u_urd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== verif/unsigned_to_radix_digits_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// unsigned_to_radix_digits_unit_tb : digit string checker for the converter
// Sends unsigned values with bases across the whole 5-bit field. A local
// divider model predicts the character stream, and every character that
// leaves the block is checked against it, tlast included. Apart from one
// full-rate phase, random idle gaps space both requests and characters.
// ----------------------------------------------------------------------------
module unsigned_to_radix_digits_unit_tb;
    import urd_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake at all
    localparam int DRAIN_TAIL     = 64;    // settle time once nothing is owed

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } digit_char_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;     // [31:0] value, [36:32] base, [39:37] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;           // [5:0] digit_char, [7:6] zero
    logic        m_tlast;

    digit_char_t expected_chars[$];
    bit          idle_on         = 1'b1;
    int          errors          = 0;
    int          numbers_sent    = 0;
    int          chars_checked   = 0;
    int          saturated_bases = 0;
    int          rx_wait         = 0;
    int          quiet_cycles    = 0;

    unsigned_to_radix_digits_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Divide repeatedly by the clamped base, then queue the digits in
    // reverse order so the most significant character is owed first.
    task automatic predict_digits(input logic [VALUE_FIELD_W-1:0] value,
                                  input logic [BASE_W-1:0] base);
        logic [BASE_W-1:0]        radix;
        logic [VALUE_FIELD_W-1:0] quot;
        logic [DIGIT_W-1:0]       digits[VALUE_BITS_DEF];
        int                       n;
        digit_char_t              item;
        radix = (base < RADIX_MIN) ? RADIX_MIN : (base > RADIX_MAX) ? RADIX_MAX : base;
        if (radix != base)
            saturated_bases++;
        quot = value;
        n = 0;
        do begin
            digits[n] = DIGIT_W'(quot % radix);
            n++;
            quot = quot / radix;
        end while (quot != 0 && n < VALUE_BITS_DEF);
        for (int k = n - 1; k >= 0; k--) begin
            item.ch   = DIGIT_ZERO + CHAR_W'(digits[k]);
            item.last = (k == 0);
            expected_chars.push_back(item);
        end
    endtask

    // Offer one request. Valid is left high after the handshake; the next
    // call drops it only when it draws a gap, so it never moves twice in a step.
    task automatic send_number(input logic [VALUE_FIELD_W-1:0] value,
                               input logic [BASE_W-1:0] base);
        int gap;
        gap = idle_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, base, value};
        do @(posedge aclk); while (!s_tready);
        predict_digits(value, base);
        numbers_sent++;
    endtask

    // Result side: hold tready low for a drawn number of cycles after each
    // accepted character, otherwise keep it high.
    always @(posedge aclk) begin
        int w;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else if (m_tvalid && m_tready) begin
            w = idle_on ? $urandom_range(0, 7) : 0;
            rx_wait  <= w;
            m_tready <= (w == 0);
        end else if (rx_wait > 0) begin
            rx_wait  <= rx_wait - 1;
            m_tready <= (rx_wait == 1);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each accepted character with the oldest one owed.
    always @(posedge aclk) begin
        digit_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                $error("unexpected character %0d (last %0d)", m_tdata[CHAR_W-1:0], m_tlast);
                errors++;
            end else begin
                want = expected_chars.pop_front();
                chars_checked++;
                if (m_tdata[CHAR_W-1:0] !== want.ch) begin
                    $error("digit_char expected %0d got %0d", want.ch, m_tdata[CHAR_W-1:0]);
                    errors++;
                end
                if (m_tlast !== want.last) begin
                    $error("last expected %0d got %0d", want.last, m_tlast);
                    errors++;
                end
            end
        end
    end

    // Abort when neither side has moved for far longer than the slowest number.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !aresetn) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Zero, full-scale values, saturated bases, digits above nine, carries.
    task automatic test_directed();
        send_number(32'd0, 5'd2);
        send_number(32'd0, 5'd16);
        send_number(32'd0, 5'd0);
        send_number(32'hFFFF_FFFF, 5'd2);
        send_number(32'hFFFF_FFFF, 5'd16);
        send_number(32'hFFFF_FFFF, 5'd10);
        send_number(32'hFFFF_FFFF, 5'd3);
        send_number(32'h8000_0000, 5'd2);
        send_number(32'd1, 5'd2);
        send_number(32'd5, 5'd0);
        send_number(32'd5, 5'd1);
        send_number(32'h0000_0FFF, 5'd17);
        send_number(32'hDEAD_BEEF, 5'd31);
        send_number(32'hDEAD_BEEF, 5'd16);
        send_number(32'h0123_4567, 5'd16);
        send_number(32'd10, 5'd10);
        send_number(32'd9, 5'd10);
        send_number(32'd15, 5'd16);
        send_number(32'd16, 5'd16);
        send_number(32'd1000000, 5'd7);
        send_number(32'h5555_5555, 5'd4);
    endtask

    // Full 32-bit values; mostly legal bases with some from the whole field.
    task automatic test_random_wide();
        logic [BASE_W-1:0] base;
        repeat (80) begin
            base = ($urandom_range(0, 9) == 0) ? BASE_W'($urandom_range(0, 31))
                                               : BASE_W'($urandom_range(2, 16));
            send_number($urandom, base);
        end
    endtask

    // Short values, so that numbers of one or two digits follow each other.
    task automatic test_random_short();
        repeat (80)
            send_number($urandom >> $urandom_range(0, 31),
                        BASE_W'($urandom_range(2, 16)));
    endtask

    // Back-to-back requests with both sides always ready.
    task automatic test_full_rate();
        idle_on = 1'b0;
        repeat (60)
            send_number($urandom >> $urandom_range(0, 31), BASE_W'($urandom_range(0, 31)));
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_random_wide();
        test_random_short();
        test_full_rate();

        s_tvalid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_TAIL) @(posedge aclk);

        $display("converted %0d numbers into %0d checked characters", numbers_sent,
                 chars_checked);
        $display("%0d requests carried a base outside 2..16", saturated_bases);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
